// File: rtl/core/frie_pkg.sv
// Shared types and constants for the four-register instruction executor.
package frie_pkg;

  // Datapath and storage sizes.
  localparam int DataW    = 32;
  localparam int MemDepth = 256;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int NumRegs  = 4;
  localparam int RegIdxW  = $clog2(NumRegs);
  localparam int LineW    = 16;
  localparam int OpW      = 4;
  localparam int KindW    = 2;
  localparam int CntW     = $clog2(DataW);

  // Operation codes.
  localparam logic [OpW-1:0] OP_MOV = 4'd0;
  localparam logic [OpW-1:0] OP_INC = 4'd1;
  localparam logic [OpW-1:0] OP_DEC = 4'd2;
  localparam logic [OpW-1:0] OP_MUL = 4'd3;
  localparam logic [OpW-1:0] OP_DIV = 4'd4;
  localparam logic [OpW-1:0] OP_CMP = 4'd5;
  localparam logic [OpW-1:0] OP_JMP = 4'd6;
  localparam logic [OpW-1:0] OP_ADD = 4'd7;
  localparam logic [OpW-1:0] OP_SUB = 4'd8;

  // Source operand kinds; every other code reads the immediate.
  localparam logic [KindW-1:0] SRC_REG = 2'd0;
  localparam logic [KindW-1:0] SRC_MEM = 2'd1;

  // Register A is the fixed destination of MUL and DIV.
  localparam logic [RegIdxW-1:0] REG_A = 2'd0;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_SRC,
    ST_LD_DST,
    ST_SETUP,
    ST_ALU,
    ST_MUL,
    ST_DIV_PREP,
    ST_DIV,
    ST_DIV_SIGN,
    ST_WRITE
  } fsm_state_t;

  // One decoded instruction.
  typedef struct packed {
    logic [OpW-1:0]       req_type;
    logic                 dst_is_mem;
    logic [RegIdxW-1:0]   dst_reg;
    logic [AddrW-1:0]     dst_addr;
    logic [KindW-1:0]     src_kind;
    logic [RegIdxW-1:0]   src_reg;
    logic [AddrW-1:0]     src_addr;
    logic signed [31:0]   src_imm;
    logic [LineW-1:0]     jump_line;
  } in_beat_t;

  // One instruction result.
  typedef struct packed {
    logic                 zero_out;
    logic                 branch_taken;
    logic [LineW-1:0]     branch_target;
    logic                 dest_written;
    logic signed [31:0]   dest_value;
    logic                 div_zero;
  } out_beat_t;

endpackage

// File: rtl/core/four_register_instruction_executor_unit.sv
// Top level of the four-register instruction executor: sequencer and shared adder.

// Executes one decoded instruction per input beat on registers A to D, a
// 256-word data memory and a zero flag, and returns one result beat for each.
// A single 33-bit adder/subtractor does all arithmetic under a small
// sequencer, so the block takes one instruction at a time and drops in_ready
// until it has finished. MUL runs 32 shift-and-add steps of the adder; DIV
// runs a magnitude setup, 32 restoring-division steps and a sign fix, and
// skips all of them when the divisor is zero. The source and destination
// are read one after the other through the single read port of the data
// memory. The next instruction is accepted while a result still waits on the
// out channel. The data memory reads as zero after reset through one valid
// bit per word, so no clearing pass is needed.
module four_register_instruction_executor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frie_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frie_pkg::out_beat_t out_data
);
  import frie_pkg::*;

  // Sequencer and working registers.
  fsm_state_t              state_r, state_nxt;
  in_beat_t                req_r, req_nxt;
  logic [DataW-1:0]        opa_r, opa_nxt;
  logic [DataW-1:0]        opb_r, opb_nxt;
  logic [DataW-1:0]        res_r, res_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    wr_r, wr_nxt;
  logic                    dz_r, dz_nxt;
  logic                    zero_r, zero_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  // Architectural storage.
  logic [DataW-1:0]        regs_r [NumRegs];
  logic [DataW-1:0]        mem [MemDepth];
  logic [MemDepth-1:0]     mem_vld_r;
  logic [DataW-1:0]        mem_rdata_r;
  logic                    rd_vld_r;
  logic [AddrW-1:0]        rd_addr;
  logic [DataW-1:0]        mem_rd;

  // Shared adder.
  logic [DataW-1:0]        add_a, add_b;
  logic                    add_sub;
  logic [DataW:0]          add_sum;

  // Decode helpers.
  logic                    is_muldiv;
  logic                    slot_free;
  logic                    commit;
  logic                    to_mem;
  logic [RegIdxW-1:0]      wr_idx;
  logic [DataW-1:0]        div_shift;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_muldiv = (req_r.req_type == OP_MUL) || (req_r.req_type == OP_DIV);
  assign slot_free = !out_valid_r || out_ready;
  assign commit    = (state_r == ST_WRITE) && slot_free;
  assign to_mem    = req_r.dst_is_mem && !is_muldiv;
  assign wr_idx    = is_muldiv ? REG_A : req_r.dst_reg;
  assign mem_rd    = rd_vld_r ? mem_rdata_r : '0;
  assign div_shift = {res_r[DataW-2:0], opa_r[DataW-1]};

  // The one adder/subtractor; bit DataW is the carry, set on a >= b in subtraction.
  assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + {{DataW{1'b0}}, add_sub};

  // Memory read address: source word first, then destination word.
  assign rd_addr = (state_r == ST_LD_SRC) ? req_r.src_addr : req_r.dst_addr;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LD_SRC;
      end
      ST_LD_SRC: state_nxt = ST_LD_DST;
      ST_LD_DST: state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (req_r.req_type == OP_MUL) begin
          state_nxt = ST_MUL;
        end else if (req_r.req_type == OP_DIV) begin
          state_nxt = (opb_r == '0) ? ST_WRITE : ST_DIV_PREP;
        end else begin
          state_nxt = ST_ALU;
        end
      end
      ST_ALU: state_nxt = ST_WRITE;
      ST_MUL: begin
        if (cnt_r == '0) state_nxt = ST_WRITE;
      end
      ST_DIV_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_DIV_SIGN;
      end
      ST_DIV_SIGN: state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and working register updates.
  always_comb begin
    req_nxt       = req_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    wr_nxt        = wr_r;
    dz_nxt        = dz_r;
    zero_nxt      = zero_r;
    add_a         = opa_r;
    add_b         = opb_r;
    add_sub       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) req_nxt = in_data;
      end
      ST_LD_SRC: begin
      end
      // Source operand; the memory word was read in the previous cycle.
      ST_LD_DST: begin
        case (req_r.src_kind)
          SRC_REG: opb_nxt = regs_r[req_r.src_reg];
          SRC_MEM: opb_nxt = mem_rd;
          default: opb_nxt = $unsigned(req_r.src_imm);
        endcase
      end
      // Destination operand, and a zero divisor is caught here.
      ST_SETUP: begin
        if (is_muldiv) begin
          opa_nxt = regs_r[REG_A];
        end else if (req_r.dst_is_mem) begin
          opa_nxt = mem_rd;
        end else begin
          opa_nxt = regs_r[req_r.dst_reg];
        end
        res_nxt = '0;
        wr_nxt  = 1'b0;
        dz_nxt  = (req_r.req_type == OP_DIV) && (opb_r == '0);
        cnt_nxt = '1;
      end
      // Single-pass operations.
      ST_ALU: begin
        case (req_r.req_type)
          OP_MOV: begin
            res_nxt = opb_r;
            wr_nxt  = 1'b1;
          end
          OP_INC: begin
            add_b   = {{(DataW-1){1'b0}}, 1'b1};
            res_nxt = add_sum[DataW-1:0];
            wr_nxt  = 1'b1;
          end
          OP_DEC: begin
            add_b   = {{(DataW-1){1'b0}}, 1'b1};
            add_sub = 1'b1;
            res_nxt = add_sum[DataW-1:0];
            wr_nxt  = 1'b1;
          end
          OP_ADD: begin
            res_nxt = add_sum[DataW-1:0];
            wr_nxt  = 1'b1;
          end
          OP_SUB: begin
            add_sub = 1'b1;
            res_nxt = add_sum[DataW-1:0];
            wr_nxt  = 1'b1;
          end
          OP_CMP: begin
            add_sub  = 1'b1;
            zero_nxt = (add_sum[DataW-1:0] == '0);
          end
          default: begin
          end
        endcase
      end
      // Shift-and-add multiply, one multiplier bit per cycle, low word kept.
      ST_MUL: begin
        add_a   = res_r;
        add_b   = opa_r;
        if (opb_r[0]) res_nxt = add_sum[DataW-1:0];
        opa_nxt = {opa_r[DataW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[DataW-1:1]};
        cnt_nxt = cnt_r - CntW'(1);
        if (cnt_r == '0) wr_nxt = 1'b1;
      end
      // Take the dividend's magnitude on the adder and remember the quotient sign.
      ST_DIV_PREP: begin
        add_a   = '0;
        add_b   = opa_r;
        add_sub = opa_r[DataW-1];
        neg_nxt = opa_r[DataW-1] ^ opb_r[DataW-1];
        opa_nxt = add_sum[DataW-1:0];
        res_nxt = '0;
        cnt_nxt = '1;
      end
      // Restoring division: remainder in res_r, quotient shifts into opa_r.
      // A negative divisor is added rather than subtracted, which gives the
      // same carry and difference as subtracting its magnitude.
      ST_DIV: begin
        add_a   = div_shift;
        add_b   = opb_r;
        add_sub = !opb_r[DataW-1];
        res_nxt = add_sum[DataW] ? add_sum[DataW-1:0] : div_shift;
        opa_nxt = {opa_r[DataW-2:0], add_sum[DataW]};
        cnt_nxt = cnt_r - CntW'(1);
      end
      // Negate the quotient when the operand signs differ.
      ST_DIV_SIGN: begin
        add_a   = '0;
        add_b   = opa_r;
        add_sub = neg_r;
        res_nxt = add_sum[DataW-1:0];
        wr_nxt  = 1'b1;
      end
      // Hand the result beat to the output register.
      ST_WRITE: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.zero_out      = zero_r;
          out_data_nxt.branch_taken  = (req_r.req_type == OP_JMP) && !zero_r;
          out_data_nxt.branch_target = ((req_r.req_type == OP_JMP) && !zero_r)
                                       ? req_r.jump_line : '0;
          out_data_nxt.dest_written  = wr_r;
          out_data_nxt.dest_value    = wr_r ? $signed(res_r) : '0;
          out_data_nxt.div_zero      = dz_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and the register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
      mem_vld_r   <= '0;
      for (int i = 0; i < NumRegs; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      zero_r      <= zero_nxt;
      if (commit && wr_r) begin
        if (to_mem) begin
          mem_vld_r[req_r.dst_addr] <= 1'b1;
        end else begin
          regs_r[wr_idx] <= res_r;
        end
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    res_r      <= res_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    wr_r       <= wr_nxt;
    dz_r       <= dz_nxt;
    out_data_r <= out_data_nxt;
  end

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (commit && wr_r && to_mem) begin
      mem[req_r.dst_addr] <= res_r;
    end
    mem_rdata_r <= mem[rd_addr];
    rd_vld_r    <= mem_vld_r[rd_addr];
  end

endmodule
